// ----- rtl/n2s_pkg.sv -----
`timescale 1ns / 1ps

package n2s_pkg;

   localparam int unsigned MSG_BYTES = 10;
   localparam int unsigned IDX_W = $clog2(MSG_BYTES);
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [7:0] PACE_TICKS = 8'd32;
   localparam logic [6:0] EFFECT_CLAMP = 7'd20;

   localparam logic [7:0] HDR_ID = 8'h42;
   localparam logic [7:0] HDR_MODEL = 8'h32;
   localparam logic [7:0] HDR_DEV = 8'h7F;
   localparam logic [7:0] HDR_FUNC = 8'h41;
   localparam logic [7:0] BANK_PATTERN = 8'h62;
   localparam logic [7:0] BANK_EFFECT = 8'h50;

   localparam logic [1:0] REG_SAMPLE_SEL = 2'd0;
   localparam logic [1:0] REG_PATTERN_SEL = 2'd1;
   localparam logic [1:0] REG_EFFECT_SEL = 2'd2;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MSG_BYTES - 1);

   typedef struct packed {
      logic [7:0] b4;
      logic [7:0] b6;
      logic [7:0] b8;
      logic [7:0] b9;
   } n2s_msg_type;

   function automatic logic [7:0] msg_byte(input n2s_msg_type msg,
                                           input logic [IDX_W-1:0] idx);
      logic [7:0] b;
      b = 8'h00;
      case (idx)
         4'd0: b = HDR_ID;
         4'd1: b = HDR_MODEL;
         4'd2: b = HDR_DEV;
         4'd3: b = HDR_FUNC;
         4'd4: b = msg.b4;
         4'd6: b = msg.b6;
         4'd8: b = msg.b8;
         4'd9: b = msg.b9;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// ----- rtl/n2s_front.sv -----
`timescale 1ns / 1ps

module n2s_front
   import n2s_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        cmd,
   input  logic [13:0] param_number,
   input  logic [13:0] param_value,
   input  logic        csr_valid,
   input  logic [1:0]  csr_index,
   input  logic [13:0] csr_data,
   output logic        push_valid,
   input  logic        push_ready,
   output n2s_msg_type push_msg
);

   logic [13:0] sample_num_ff, pattern_num_ff, effect_num_ff;
   logic [7:0]  pace_ff, pace_in;
   logic        pend_valid_ff, pend_valid_in;
   n2s_msg_type pend_ff, pend_in;
   logic [6:0]  sample_sel_ff, sample_sel_in;
   logic [6:0]  pattern_sel_ff, pattern_sel_in;
   logic [6:0]  effect_sel_ff, effect_sel_in;

   logic        accept;
   logic [7:0]  pace_dec;
   logic [6:0]  target, low, tgt;
   logic [7:0]  low8;
   logic        mapped;
   n2s_msg_type built;

   assign req_tready = push_ready;
   assign accept = req_tvalid & push_ready;
   assign pace_dec = (pace_ff != 8'd0) ? pace_ff - 8'd1 : 8'd0;
   assign target = param_number[13:7];
   assign low = param_number[6:0];
   assign low8 = {1'b0, low};

   always_comb begin
      mapped = 1'b1;
      tgt = target;
      built.b4 = 8'h00;
      built.b6 = 8'h00;
      built.b8 = {1'b0, param_value[13:7]};
      built.b9 = 8'h00;
      if (low <= 7'd9) begin
         if (low <= 7'd7) begin
            built.b6 = low8;
         end else if (low == 7'd8) begin
            built.b6 = 8'h10;
            built.b8 = {1'b0, param_value[6:0]};
            built.b9 = {1'b0, param_value[13:7]};
         end else begin
            built.b6 = 8'h12;
         end
      end else if (low <= 7'd11) begin
         if (target == 7'd0) tgt = pattern_sel_ff;
         built.b4 = BANK_PATTERN;
         built.b6 = (low == 7'd10) ? {1'b0, tgt} : {1'b0, tgt} + 8'd16;
      end else if (low <= 7'd30) begin
         if (target == 7'd0) tgt = sample_sel_ff;
         built.b4 = {1'b0, tgt} + 8'd16;
         if (low <= 7'd19) built.b6 = low8 - 8'd12;
         else if (low <= 7'd22) built.b6 = low8 - 8'd4;
         else if (low <= 7'd24) built.b6 = low8 - 8'd2;
         else if (low <= 7'd26) built.b6 = low8 + 8'd2;
         else if (low == 7'd27) built.b6 = 8'h18;
         else if (low == 7'd28) built.b6 = 8'h1D;
         else if (low == 7'd29) built.b6 = 8'h19;
         else built.b6 = 8'h1A;
      end else if (low <= 7'd34) begin
         tgt = (target == 7'd0) ? effect_sel_ff : target - 7'd1;
         if (tgt > EFFECT_CLAMP) tgt = EFFECT_CLAMP;
         built.b4 = BANK_EFFECT;
         built.b6 = (low <= 7'd33) ? low8 - 8'd30 : {1'b0, tgt} + 8'd16;
      end else begin
         mapped = 1'b0;
      end
   end

   always_comb begin
      pace_in = pace_ff;
      pend_valid_in = pend_valid_ff;
      pend_in = pend_ff;
      sample_sel_in = sample_sel_ff;
      pattern_sel_in = pattern_sel_ff;
      effect_sel_in = effect_sel_ff;
      push_valid = 1'b0;
      push_msg = built;
      if (accept) begin
         pace_in = pace_dec;
         if (cmd) begin
            if (param_number == sample_num_ff) begin
               sample_sel_in = param_value[13:7];
            end else if (param_number == pattern_num_ff) begin
               pattern_sel_in = param_value[13:7];
            end else if (param_number == effect_num_ff) begin
               effect_sel_in = param_value[13:7];
            end else if (pace_dec == 8'd0 && pend_valid_ff) begin
               pend_valid_in = 1'b0;
               pace_in = PACE_TICKS;
               push_valid = 1'b1;
               push_msg = pend_ff;
            end else if (mapped) begin
               if (pace_dec != 8'd0) begin
                  pend_in = built;
                  pend_valid_in = 1'b1;
               end else begin
                  pace_in = PACE_TICKS;
                  push_valid = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      if (reset) begin
         sample_num_ff <= 14'd16381;
         pattern_num_ff <= 14'd16382;
         effect_num_ff <= 14'd16383;
         pace_ff <= 8'd0;
         pend_valid_ff <= 1'b0;
         sample_sel_ff <= 7'd0;
         pattern_sel_ff <= 7'd0;
         effect_sel_ff <= 7'd0;
      end else begin
         pace_ff <= pace_in;
         pend_valid_ff <= pend_valid_in;
         sample_sel_ff <= sample_sel_in;
         pattern_sel_ff <= pattern_sel_in;
         effect_sel_ff <= effect_sel_in;
         if (csr_valid) begin
            unique case (csr_index)
               REG_SAMPLE_SEL:  sample_num_ff <= csr_data;
               REG_PATTERN_SEL: pattern_num_ff <= csr_data;
               REG_EFFECT_SEL:  effect_num_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

endmodule

// ----- rtl/n2s_queue.sv -----
`timescale 1ns / 1ps

module n2s_queue
   import n2s_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   output logic        push_ready,
   input  n2s_msg_type push_msg,
   output logic        pop_valid,
   input  logic        pop_ready,
   output n2s_msg_type pop_msg
);

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

   n2s_msg_type slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != (PTR_W + 1)'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_msg = slot_ff[rd_ptr_ff];
   assign do_push = push_valid & push_ready;
   assign do_pop = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_msg;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- rtl/n2s_back.sv -----
`timescale 1ns / 1ps

module n2s_back
   import n2s_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        pop_valid,
   output logic        pop_ready,
   input  n2s_msg_type pop_msg,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast
);

   n2s_msg_type      msg_ff, msg_in;
   logic             busy_ff, busy_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             last_taken;

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata = msg_byte(msg_ff, idx_ff);
   assign rsp_tlast = (idx_ff == LAST_IDX);
   assign last_taken = busy_ff & rsp_tready & rsp_tlast;
   assign pop_ready = !busy_ff || last_taken;

   always_comb begin
      msg_in = msg_ff;
      busy_in = busy_ff;
      idx_in = idx_ff;
      if (busy_ff && rsp_tready && !rsp_tlast) begin
         idx_in = idx_ff + 1'b1;
      end
      if (pop_ready) begin
         busy_in = pop_valid;
         idx_in = '0;
         if (pop_valid) msg_in = pop_msg;
      end
   end

   always_ff @(posedge clock) begin
      msg_ff <= msg_in;
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff <= idx_in;
      end
   end

endmodule

// ----- rtl/nrpn_to_sysex_rate_limiter.sv -----
`timescale 1ns / 1ps
// NRPN to sysex translator with output pacing.
// req channel: one item per handshake; tuser carries cmd (0 = tick only,
// 1 = NRPN item), tdata carries param_number [13:0] and param_value [27:14].
// rsp channel: one message byte per handshake, ten bytes per message, tlast
// on the tenth byte.
// csr channel: csr_index selects the sample, pattern or effect selector
// number (0, 1, 2); csr_data is the 14-bit value. csr_ready is always high.
// The request that causes a message is registered in the queue slot, then
// in the serialiser, whose busy flag drives rsp_tvalid. Requests are taken
// one per cycle while the two-entry message queue has room; the byte
// serialiser drains one message at a time, one byte per handshake, so
// sustained rate is set by it when every request yields a message.
// Reset clears pacing, pending and selector state, empties the queue and
// restores the default selector numbers. When the receiver stalls, the
// current byte holds, the queue fills and then req_tready drops.
module nrpn_to_sysex_rate_limiter
   import n2s_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // param_number [13:0], param_value [27:14], zero pad
   input  logic        req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte [7:0]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [13:0] csr_data
);

   logic        push_valid, push_ready, pop_valid, pop_ready;
   n2s_msg_type push_msg, pop_msg;
   logic [3:0]  pad_unused;

   assign csr_ready = 1'b1;
   assign pad_unused = req_tdata[31:28];

   n2s_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .cmd          (req_tuser),
      .param_number (req_tdata[13:0]),
      .param_value  (req_tdata[27:14]),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_msg     (push_msg)
   );

   n2s_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_msg   (push_msg),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_msg    (pop_msg)
   );

   n2s_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_msg    (pop_msg),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- test/n2s_sysex_checker.sv -----
`timescale 1ns / 1ps

module n2s_sysex_checker
   import n2s_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [13:0] csr_data,
   output int          mismatches,
   output int          outstanding
);

   localparam logic [7:0] SYX_ID = 8'h42;
   localparam logic [7:0] SYX_MODEL = 8'h32;
   localparam logic [7:0] SYX_DEV = 8'h7F;
   localparam logic [7:0] SYX_FUNC = 8'h41;
   localparam logic [7:0] SYX_PATTERN_BANK = 8'h62;
   localparam logic [7:0] SYX_EFFECT_BANK = 8'h50;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } sysex_byte_type;

   sysex_byte_type bytes_due [$];
   int            errs;
   logic [13:0]   sel_number [0:2];
   logic [7:0]    pace;
   logic          held_ok;
   n2s_msg_type   held_msg;
   logic [6:0]    sample_sel;
   logic [6:0]    pattern_sel;
   logic [6:0]    effect_sel;

   task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
      $display("checker: %s at %0t: got %h, want %h", what, $time, got, want);
      errs++;
   endtask

   function automatic logic build_sysex(input logic [13:0] pnum, input logic [13:0] pval,
                                        output n2s_msg_type m);
      logic [6:0] tgt;
      logic [6:0] low;
      logic [7:0] low8;
      tgt = pnum[13:7];
      low = pnum[6:0];
      low8 = {1'b0, low};
      m = '0;
      m.b8 = {1'b0, pval[13:7]};
      if (low <= 7'd9) begin
         if (low <= 7'd7) begin
            m.b6 = low8;
         end else if (low == 7'd8) begin
            m.b6 = 8'h10;
            m.b8 = {1'b0, pval[6:0]};
            m.b9 = {1'b0, pval[13:7]};
         end else begin
            m.b6 = 8'h12;
         end
      end else if (low <= 7'd11) begin
         if (tgt == 7'd0) tgt = pattern_sel;
         m.b4 = SYX_PATTERN_BANK;
         m.b6 = (low == 7'd10) ? {1'b0, tgt} : {1'b0, tgt} + 8'd16;
      end else if (low <= 7'd30) begin
         if (tgt == 7'd0) tgt = sample_sel;
         m.b4 = {1'b0, tgt} + 8'd16;
         if (low <= 7'd19) m.b6 = low8 - 8'd12;
         else if (low <= 7'd22) m.b6 = low8 - 8'd4;
         else if (low <= 7'd24) m.b6 = low8 - 8'd2;
         else if (low <= 7'd26) m.b6 = low8 + 8'd2;
         else if (low == 7'd27) m.b6 = 8'h18;
         else if (low == 7'd28) m.b6 = 8'h1D;
         else if (low == 7'd29) m.b6 = 8'h19;
         else m.b6 = 8'h1A;
      end else if (low <= 7'd34) begin
         if (tgt == 7'd0) tgt = effect_sel;
         else tgt = tgt - 7'd1;
         if (tgt > EFFECT_CLAMP) tgt = EFFECT_CLAMP;
         m.b4 = SYX_EFFECT_BANK;
         m.b6 = (low <= 7'd33) ? low8 - 8'd30 : {1'b0, tgt} + 8'd16;
      end else begin
         return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic queue_message(input n2s_msg_type m);
      logic [7:0] msg [0:9];
      msg = '{SYX_ID, SYX_MODEL, SYX_DEV, SYX_FUNC, m.b4, 8'h00, m.b6, 8'h00, m.b8, m.b9};
      for (int k = 0; k < 10; k++) begin
         bytes_due.push_back({msg[k], k == 9});
      end
   endtask

   task automatic take_request(input logic is_nrpn, input logic [13:0] pnum,
                               input logic [13:0] pval);
      n2s_msg_type m;
      if (pace != 8'd0) pace = pace - 8'd1;
      if (!is_nrpn) return;
      if (pnum == sel_number[REG_SAMPLE_SEL]) begin
         sample_sel = pval[13:7];
         return;
      end
      if (pnum == sel_number[REG_PATTERN_SEL]) begin
         pattern_sel = pval[13:7];
         return;
      end
      if (pnum == sel_number[REG_EFFECT_SEL]) begin
         effect_sel = pval[13:7];
         return;
      end
      if (pace == 8'd0 && held_ok) begin
         held_ok = 1'b0;
         pace = PACE_TICKS;
         queue_message(held_msg);
         return;
      end
      if (!build_sysex(pnum, pval, m)) return;
      if (pace != 8'd0) begin
         held_msg = m;
         held_ok = 1'b1;
         return;
      end
      pace = PACE_TICKS;
      queue_message(m);
   endtask

   always @(posedge clock) begin
      sysex_byte_type want;
      if (reset) begin
         sel_number[REG_SAMPLE_SEL] = 14'd16381;
         sel_number[REG_PATTERN_SEL] = 14'd16382;
         sel_number[REG_EFFECT_SEL] = 14'd16383;
         pace = 8'd0;
         held_ok = 1'b0;
         sample_sel = 7'd0;
         pattern_sel = 7'd0;
         effect_sel = 7'd0;
         bytes_due.delete();
      end else begin
         if (csr_valid && csr_ready && csr_index <= REG_EFFECT_SEL) begin
            sel_number[csr_index] = csr_data;
         end
         if (req_tvalid && req_tready) begin
            take_request(req_tuser, req_tdata[13:0], req_tdata[27:14]);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (bytes_due.size() == 0) begin
               report("byte with nothing due", rsp_tdata, 8'h00);
            end else begin
               want = bytes_due.pop_front();
               if (rsp_tdata !== want.data) report("byte", rsp_tdata, want.data);
               if (rsp_tlast !== want.last) begin
                  report("last flag", {7'd0, rsp_tlast}, {7'd0, want.last});
               end
            end
         end
      end
      outstanding <= bytes_due.size();
      mismatches <= errs;
   end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import n2s_pkg::*;

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_NRPN = 1'b1;
   localparam logic [1:0] REG_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 400000;

   localparam logic [13:0] DIRECTED_NUMS [0:19] = '{
      {7'd5, 7'd7}, {7'd3, 7'd9}, {7'd0, 7'd10}, {7'd127, 7'd11}, {7'd0, 7'd12},
      {7'd64, 7'd19}, {7'd1, 7'd20}, {7'd2, 7'd22}, {7'd4, 7'd23}, {7'd8, 7'd24},
      {7'd16, 7'd25}, {7'd32, 7'd26}, {7'd100, 7'd27}, {7'd90, 7'd28}, {7'd45, 7'd29},
      {7'd111, 7'd30}, {7'd0, 7'd31}, {7'd1, 7'd33}, {7'd127, 7'd34}, {7'd10, 7'd34}
   };

   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PATTERN} rx_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [13:0] csr_data = '0;

   int          mismatches;
   int          outstanding;
   int          cycle_count = 0;
   int          burst_left = 0;
   int          stall_left = 0;
   rx_mode_type stall_mode = RX_OPEN;
   logic [7:0]  stall_mask = 8'hFF;
   logic [13:0] sel_number [0:2] = '{14'd16381, 14'd16382, 14'd16383};

   nrpn_to_sysex_rate_limiter DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   n2s_sysex_checker sysex_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= rx_mode_type'($urandom_range(0, 2));
         stall_left <= $urandom_range(20, 120);
         stall_mask <= 8'($urandom) | 8'h01;
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         RX_OPEN: rsp_tready <= 1'b1;
         RX_COIN: rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= stall_mask[cycle_count[2:0]];
      endcase
   end

   task automatic push_request(input logic cmd, input logic [13:0] pnum,
                               input logic [13:0] pval);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 10);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {4'h0, pval, pnum};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic push_ticks(input int n);
      repeat (n) push_request(CMD_TICK, 14'($urandom), 14'($urandom));
   endtask

   task automatic push_random_request();
      int unsigned pick;
      logic [6:0]  tgt;
      logic [13:0] pval;
      pick = $urandom_range(0, 99);
      pval = 14'($urandom);
      tgt = ($urandom_range(0, 3) == 0) ? 7'd0 : 7'($urandom);
      if (pick < 55) begin
         push_request(CMD_TICK, 14'($urandom), pval);
      end else if (pick < 67) begin
         push_request(CMD_NRPN, sel_number[$urandom_range(0, 2)], pval);
      end else if (pick < 75) begin
         push_request(CMD_NRPN, {tgt, 7'($urandom_range(35, 127))}, pval);
      end else begin
         push_request(CMD_NRPN, {tgt, 7'($urandom_range(0, 34))}, pval);
      end
   endtask

   task automatic hold_until_drained(input int settle);
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [13:0] s0, input logic [13:0] s1,
                                 input logic [13:0] s2, input logic [13:0] spare);
      logic [13:0] vals [0:3];
      vals = '{s0, s1, s2, spare};
      for (int k = 0; k < 4; k++) begin
         csr_valid <= 1'b1;
         csr_index <= 2'(k);
         csr_data <= vals[k];
         do @(posedge clock); while (!csr_ready);
         if (2'(k) != REG_UNUSED) sel_number[k] = vals[k];
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      push_request(CMD_NRPN, {7'd0, 7'd0}, 14'h3FFF);
      push_request(CMD_NRPN, sel_number[REG_SAMPLE_SEL], 14'h3FFF);
      push_request(CMD_NRPN, sel_number[REG_PATTERN_SEL], 14'h2A80);
      push_request(CMD_NRPN, sel_number[REG_EFFECT_SEL], 14'h3F80);
      push_request(CMD_NRPN, {7'd127, 7'd8}, 14'h3FFF);
      push_request(CMD_NRPN, {7'd1, 7'd35}, 14'h1234);
      push_ticks(26);
      push_request(CMD_NRPN, {7'd126, 7'd127}, 14'h0000);
      foreach (DIRECTED_NUMS[i]) begin
         push_ticks(7);
         push_request(CMD_NRPN, DIRECTED_NUMS[i], 14'($urandom));
      end
      push_ticks(7);
      push_request(CMD_NRPN, {7'd9, 7'd8}, 14'h0000);

      repeat (40) push_random_request();
      hold_until_drained(0);
      repeat (40) push_random_request();
      hold_until_drained(4);

      apply_settings(14'd0, 14'd0, 14'd0, 14'h2AAA);
      push_request(CMD_NRPN, 14'd0, 14'h3FFF);
      repeat (42) push_random_request();
      hold_until_drained(4);

      apply_settings(14'h3FFF, 14'd0, 14'h3FFF, 14'h1555);
      repeat (42) push_random_request();
      hold_until_drained(4);

      apply_settings({7'($urandom), 7'($urandom_range(0, 34))},
                     {7'($urandom), 7'($urandom_range(0, 34))},
                     {7'($urandom), 7'($urandom_range(0, 34))}, 14'($urandom));
      repeat (44) push_random_request();
      hold_until_drained(10);

      if (mismatches == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/n2s_pkg.sv
rtl/n2s_front.sv
rtl/n2s_queue.sv
rtl/n2s_back.sv
rtl/nrpn_to_sysex_rate_limiter.sv
test/n2s_sysex_checker.sv
test/tb.sv
